FILE: hdl/apo_pkg.sv
// ----------------------------------------------------------------------------
// apo_pkg: shared types and constants of the acceleration observer
// Holds the sequencer states, command and register codes, and the fixed
// constants of the time-constant division and the exponential iteration.
// ----------------------------------------------------------------------------
package apo_pkg;

    // Item kinds carried in s_tuser.
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_DRIVE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_TAU_X = 2'd0;
    localparam logic [1:0] REG_TAU_Y = 2'd1;
    localparam logic [1:0] REG_GAP   = 2'd2;

    localparam int CFG_W          = 32;
    localparam int STAMP_W        = 63;
    localparam int RATIO_FRAC     = 24;
    localparam int DIVIDEND_W     = CFG_W + RATIO_FRAC;
    localparam int TAYLOR_TERMS   = 13;
    localparam int RECIP_SHIFT    = 37;
    localparam int RECIP_W        = 38;
    localparam int Q32_W          = 33;
    localparam logic [30:0] E1_Q32 = 31'd1580030169;
    localparam logic [31:0] GAP_RESET = 32'd250000000;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_AX_START,
        ST_AX_DIV,
        ST_AX_RATIO,
        ST_TAY_M1,
        ST_TAY_M2,
        ST_TAY_U,
        ST_EXP_M,
        ST_EXP_U,
        ST_ALPHA,
        ST_BL_M1,
        ST_BL_U1,
        ST_BL_M2,
        ST_BL_U2,
        ST_EMIT
    } state_t;

    // Reciprocals ceil(2^37 / k): floor(x * r >> 37) equals floor(x / k) for x < 2^33.
    function automatic logic [RECIP_W-1:0] recip_q37(input logic [3:0] k);
        logic [RECIP_W-1:0] r;
        case (k)
            4'd1:    r = 38'd137438953472;
            4'd2:    r = 38'd68719476736;
            4'd3:    r = 38'd45812984491;
            4'd4:    r = 38'd34359738368;
            4'd5:    r = 38'd27487790695;
            4'd6:    r = 38'd22906492246;
            4'd7:    r = 38'd19634136211;
            4'd8:    r = 38'd17179869184;
            4'd9:    r = 38'd15270994831;
            4'd10:   r = 38'd13743895348;
            4'd11:   r = 38'd12494450316;
            4'd12:   r = 38'd11453246123;
            4'd13:   r = 38'd10572227191;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/accel_prediction_observer_unit.sv
// ----------------------------------------------------------------------------
// accel_prediction_observer_unit: three-axis acceleration observer
// First-order complementary filter with a variable time step on X and Y.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one beat per item: s_tuser is the command (sample, set
//   commanded acceleration, clear), s_tdata the measurement, stamp and drive.
//   Every sample beat yields one m_* beat with the estimate in m_tdata and
//   the restarted and held flags in m_tuser; other commands yield none.
//   cfg_* writes the time constants and the gap limit; it is always ready
//   and is to be used only while the block is idle.
// Sequencing:
//   s_tready is high only while the sequencer is idle. Drive and clear items
//   pass through the check state alone; a held or restarted sample then
//   waits in the emit state for the output slot. A filtered sample runs each
//   X and Y axis through the shared divider, 13 Taylor steps on the shared
//   multiplier, an exp(-1) step per whole unit of dt/tau, and a blend. An
//   axis whose dt/tau is 32 or more skips the Taylor and exponential steps.
//   An axis with a zero time constant skips the division and takes its
//   measurement as its estimate.
// Reset and stall:
//   aresetn clears the estimate, the drive, the stamp and the registers to
//   their defaults. A result waits in the output register while m_tready is
//   low; the next item is still accepted but its result waits for the slot.
// ----------------------------------------------------------------------------
module accel_prediction_observer_unit #(
    parameter int ACCEL_WIDTH     = 32,
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Fields from bit 0 up: sample_x, sample_y, sample_z, time_ns, drive_x,
    // drive_y, zero padding.
    input  logic [((5*ACCEL_WIDTH+63+7)/8)*8-1:0] s_tdata,
    // Fields from bit 0 up: command.
    input  logic [1:0]                            s_tuser,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0 up: accel_x, accel_y, accel_z.
    output logic [3*ACCEL_WIDTH-1:0]              m_tdata,
    // Fields from bit 0 up: restarted, held.
    output logic [1:0]                            m_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [apo_pkg::CFG_W-1:0]             cfg_data
);

    localparam int AW      = ACCEL_WIDTH;
    localparam int AF      = ALPHA_FRAC_BITS;
    localparam int MUL_A_W = (AW + 1 > apo_pkg::Q32_W) ? AW + 1 : apo_pkg::Q32_W;
    localparam int MUL_B_W = apo_pkg::RECIP_W;
    localparam int PW      = MUL_A_W + MUL_B_W;
    localparam int SW      = apo_pkg::STAMP_W;

    // Sequencer and stored state.
    apo_pkg::state_t state_reg, state_next;
    logic [1:0]             cmd_reg;
    logic signed [AW-1:0]   mx_reg, my_reg, mz_reg, dx_reg, dy_reg;
    logic [SW-1:0]          t_reg;
    logic signed [AW-1:0]   est_reg [3];
    logic signed [AW-1:0]   est_next [3];
    logic signed [AW-1:0]   drv_reg [2];
    logic signed [AW-1:0]   drv_next [2];
    logic [SW-1:0]          last_reg, last_next;
    logic                   primed_reg, primed_next;
    logic [31:0]            tau_x_reg, tau_y_reg, gap_reg;
    logic [31:0]            dt_reg, dt_next;
    logic                   ax_reg, ax_next;
    logic [4:0]             n_reg, n_next;
    logic [31:0]            f_reg, f_next;
    logic [apo_pkg::Q32_W-1:0] sum_reg, sum_next, term_reg, term_next;
    logic [3:0]             k_reg, k_next;
    logic [AF:0]            alpha_reg, alpha_next;
    logic                   neg_reg, neg_next;
    logic signed [AW-1:0]   pred_reg, pred_next;
    logic                   rst_flag_reg, rst_flag_next, held_reg, held_next;
    logic [3*AW-1:0]        out_data_reg, out_data_next;
    logic [1:0]             out_user_reg, out_user_next;
    logic                   out_valid_reg, out_valid_next;

    // Shared units.
    logic                              div_start, div_busy;
    logic [apo_pkg::DIVIDEND_W-1:0]    div_quot;
    logic [MUL_A_W-1:0]                mul_a;
    logic [MUL_B_W-1:0]                mul_b;
    logic [PW-1:0]                     prod;

    // Combinational helpers.
    logic [SW:0]            stamp_diff;
    logic [31:0]            tau_sel;
    logic signed [AW-1:0]   m_sel, u_sel;
    logic signed [AW:0]     d_val;
    logic [AW:0]            d_mag;
    logic [AW+AF:0]         blend_rnd;
    logic [AW:0]            blend_r;
    logic signed [AW+1:0]   blend_sum;
    logic signed [AW+1:0]   base_ext;
    logic [64:0]            exp_rnd;
    logic [33:0]            alpha_rnd;
    logic [AF+1:0]          alpha_raw;

    apo_divider #(
        .DIVIDEND_W (apo_pkg::DIVIDEND_W),
        .DIVISOR_W  (32)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({dt_reg, {apo_pkg::RATIO_FRAC{1'b0}}}),
        .divisor  (tau_sel),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    apo_mult #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mult (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (prod)
    );

    assign s_tready  = (state_reg == apo_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;
    assign m_tvalid  = out_valid_reg;

    // Per-axis operands, stamp difference, and blend and rounding datapath.
    always_comb begin
        tau_sel    = ax_reg ? tau_y_reg : tau_x_reg;
        m_sel      = ax_reg ? my_reg : mx_reg;
        u_sel      = ax_reg ? drv_reg[1] : drv_reg[0];
        stamp_diff = {1'b0, t_reg} - {1'b0, last_reg};
        if (state_reg == apo_pkg::ST_BL_M2) begin
            d_val = {pred_reg[AW-1], pred_reg} - {m_sel[AW-1], m_sel};
        end else begin
            d_val = (ax_reg ? {est_reg[1][AW-1], est_reg[1]} : {est_reg[0][AW-1], est_reg[0]})
                    - {u_sel[AW-1], u_sel};
        end
        d_mag     = d_val[AW] ? (AW+1)'(-d_val) : d_val;
        blend_rnd = prod[AW+AF:0] + ((AW+AF+1)'(1) << (AF - 1));
        blend_r   = blend_rnd[AW+AF:AF];
        base_ext  = (state_reg == apo_pkg::ST_BL_U1) ? {{2{u_sel[AW-1]}}, u_sel}
                                                     : {{2{m_sel[AW-1]}}, m_sel};
        blend_sum = neg_reg ? base_ext - $signed({1'b0, blend_r})
                            : base_ext + $signed({1'b0, blend_r});
        exp_rnd   = {1'b0, prod[63:0]} + 65'h0_8000_0000;
        alpha_rnd = {1'b0, sum_reg} + (34'd1 << (31 - AF));
        alpha_raw = alpha_rnd[33:32-AF];
    end

    // Multiplier operands for each step of the sequence.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            apo_pkg::ST_TAY_M1: begin
                mul_a = MUL_A_W'(term_reg);
                mul_b = MUL_B_W'(f_reg);
            end
            apo_pkg::ST_TAY_M2: begin
                mul_a = MUL_A_W'(prod[63:32]);
                mul_b = apo_pkg::recip_q37(k_reg);
            end
            apo_pkg::ST_EXP_M: begin
                mul_a = MUL_A_W'(sum_reg);
                mul_b = MUL_B_W'(apo_pkg::E1_Q32);
            end
            apo_pkg::ST_BL_M1, apo_pkg::ST_BL_M2: begin
                mul_a = MUL_A_W'(d_mag);
                mul_b = MUL_B_W'(alpha_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer: next state and datapath register updates.
    always_comb begin
        state_next     = state_reg;
        est_next       = est_reg;
        drv_next       = drv_reg;
        last_next      = last_reg;
        primed_next    = primed_reg;
        dt_next        = dt_reg;
        ax_next        = ax_reg;
        n_next         = n_reg;
        f_next         = f_reg;
        sum_next       = sum_reg;
        term_next      = term_reg;
        k_next         = k_reg;
        alpha_next     = alpha_reg;
        neg_next       = neg_reg;
        pred_next      = pred_reg;
        rst_flag_next  = rst_flag_reg;
        held_next      = held_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_valid_next = out_valid_reg;
        div_start      = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            apo_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = apo_pkg::ST_CHECK;
                end
            end
            apo_pkg::ST_CHECK: begin
                state_next    = apo_pkg::ST_IDLE;
                rst_flag_next = 1'b0;
                held_next     = 1'b0;
                case (cmd_reg)
                    apo_pkg::CMD_DRIVE: begin
                        drv_next[0] = dx_reg;
                        drv_next[1] = dy_reg;
                    end
                    apo_pkg::CMD_CLEAR: begin
                        est_next[0] = '0;
                        est_next[1] = '0;
                        est_next[2] = '0;
                        drv_next[0] = '0;
                        drv_next[1] = '0;
                        last_next   = '0;
                        primed_next = 1'b0;
                    end
                    apo_pkg::CMD_SAMPLE: begin
                        if (primed_reg && t_reg == last_reg) begin
                            held_next  = 1'b1;
                            state_next = apo_pkg::ST_EMIT;
                        end else if (!primed_reg || stamp_diff[SW]
                                     || stamp_diff[SW-1:0] > SW'(gap_reg)) begin
                            est_next[0]   = mx_reg;
                            est_next[1]   = my_reg;
                            est_next[2]   = mz_reg;
                            last_next     = t_reg;
                            primed_next   = 1'b1;
                            rst_flag_next = 1'b1;
                            state_next    = apo_pkg::ST_EMIT;
                        end else begin
                            dt_next     = stamp_diff[31:0];
                            est_next[2] = mz_reg;
                            last_next   = t_reg;
                            ax_next     = 1'b0;
                            state_next  = apo_pkg::ST_AX_START;
                        end
                    end
                    default: begin
                        state_next = apo_pkg::ST_IDLE;
                    end
                endcase
            end
            apo_pkg::ST_AX_START: begin
                if (tau_sel == '0) begin
                    est_next[ax_reg] = m_sel;
                    ax_next          = 1'b1;
                    state_next       = ax_reg ? apo_pkg::ST_EMIT : apo_pkg::ST_AX_START;
                end else begin
                    div_start  = 1'b1;
                    state_next = apo_pkg::ST_AX_DIV;
                end
            end
            apo_pkg::ST_AX_DIV: begin
                if (!div_busy) begin
                    state_next = apo_pkg::ST_AX_RATIO;
                end
            end
            apo_pkg::ST_AX_RATIO: begin
                if (div_quot[apo_pkg::DIVIDEND_W-1:apo_pkg::RATIO_FRAC+5] != '0) begin
                    alpha_next = '0;
                    state_next = apo_pkg::ST_BL_M1;
                end else begin
                    n_next     = div_quot[apo_pkg::RATIO_FRAC+4:apo_pkg::RATIO_FRAC];
                    f_next     = {div_quot[apo_pkg::RATIO_FRAC-1:0], 8'd0};
                    sum_next   = {1'b1, 32'd0};
                    term_next  = {1'b1, 32'd0};
                    k_next     = 4'd1;
                    state_next = apo_pkg::ST_TAY_M1;
                end
            end
            apo_pkg::ST_TAY_M1: begin
                state_next = apo_pkg::ST_TAY_M2;
            end
            apo_pkg::ST_TAY_M2: begin
                state_next = apo_pkg::ST_TAY_U;
            end
            apo_pkg::ST_TAY_U: begin
                // Odd terms subtract, even terms add.
                term_next = {1'b0, prod[apo_pkg::RECIP_SHIFT+31:apo_pkg::RECIP_SHIFT]};
                sum_next  = k_reg[0] ? sum_reg - term_next : sum_reg + term_next;
                k_next    = k_reg + 1'b1;
                if (k_reg == 4'(apo_pkg::TAYLOR_TERMS)) begin
                    state_next = (n_reg != '0) ? apo_pkg::ST_EXP_M : apo_pkg::ST_ALPHA;
                end else begin
                    state_next = apo_pkg::ST_TAY_M1;
                end
            end
            apo_pkg::ST_EXP_M: begin
                state_next = apo_pkg::ST_EXP_U;
            end
            apo_pkg::ST_EXP_U: begin
                // One whole unit of dt/tau: multiply by exp(-1).
                sum_next   = exp_rnd[64:32];
                n_next     = n_reg - 1'b1;
                state_next = (n_reg == 5'd1) ? apo_pkg::ST_ALPHA : apo_pkg::ST_EXP_M;
            end
            apo_pkg::ST_ALPHA: begin
                alpha_next = (alpha_raw > (AF+2)'(1) << AF) ? (AF+1)'(1) << AF
                                                            : alpha_raw[AF:0];
                state_next = apo_pkg::ST_BL_M1;
            end
            apo_pkg::ST_BL_M1: begin
                neg_next   = d_val[AW];
                state_next = apo_pkg::ST_BL_U1;
            end
            apo_pkg::ST_BL_U1: begin
                // Prediction from the commanded acceleration.
                pred_next  = blend_sum[AW-1:0];
                state_next = apo_pkg::ST_BL_M2;
            end
            apo_pkg::ST_BL_M2: begin
                neg_next   = d_val[AW];
                state_next = apo_pkg::ST_BL_U2;
            end
            apo_pkg::ST_BL_U2: begin
                est_next[ax_reg] = blend_sum[AW-1:0];
                ax_next          = 1'b1;
                state_next       = ax_reg ? apo_pkg::ST_EMIT : apo_pkg::ST_AX_START;
            end
            apo_pkg::ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_data_next  = {est_reg[2], est_reg[1], est_reg[0]};
                    out_user_next  = {held_reg, rst_flag_reg};
                    out_valid_next = 1'b1;
                    state_next     = apo_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = apo_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= apo_pkg::ST_IDLE;
            est_reg[0]    <= '0;
            est_reg[1]    <= '0;
            est_reg[2]    <= '0;
            drv_reg[0]    <= '0;
            drv_reg[1]    <= '0;
            last_reg      <= '0;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            tau_x_reg     <= '0;
            tau_y_reg     <= '0;
            gap_reg       <= apo_pkg::GAP_RESET;
        end else begin
            state_reg     <= state_next;
            est_reg       <= est_next;
            drv_reg       <= drv_next;
            last_reg      <= last_next;
            primed_reg    <= primed_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    apo_pkg::REG_TAU_X: tau_x_reg <= cfg_data;
                    apo_pkg::REG_TAU_Y: tau_y_reg <= cfg_data;
                    apo_pkg::REG_GAP:   gap_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= s_tuser;
            mx_reg  <= s_tdata[AW-1:0];
            my_reg  <= s_tdata[2*AW-1:AW];
            mz_reg  <= s_tdata[3*AW-1:2*AW];
            t_reg   <= s_tdata[3*AW+SW-1:3*AW];
            dx_reg  <= s_tdata[4*AW+SW-1:3*AW+SW];
            dy_reg  <= s_tdata[5*AW+SW-1:4*AW+SW];
        end
        dt_reg       <= dt_next;
        ax_reg       <= ax_next;
        n_reg        <= n_next;
        f_reg        <= f_next;
        sum_reg      <= sum_next;
        term_reg     <= term_next;
        k_reg        <= k_next;
        alpha_reg    <= alpha_next;
        neg_reg      <= neg_next;
        pred_reg     <= pred_next;
        rst_flag_reg <= rst_flag_next;
        held_reg     <= held_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

endmodule

FILE: hdl/apo_divider.sv
// ----------------------------------------------------------------------------
// apo_divider: bit-serial restoring divider
// Produces one quotient bit per cycle; busy stays high after start until all
// DIVIDEND_W quotient bits are in. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module apo_divider #(
    parameter int DIVIDEND_W = 56,
    parameter int DIVISOR_W  = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [DIVISOR_W:0]    trial;
    logic                  qbit;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        trial     = {rem_reg, quot_reg[DIVIDEND_W-1]};
        qbit      = (trial >= {1'b0, dsr_reg});
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quot_next = quot_reg;
        if (start) begin
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            dsr_next  = divisor;
            quot_next = dividend;
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - 1'b1;
            rem_next  = qbit ? DIVISOR_W'(trial - {1'b0, dsr_reg}) : trial[DIVISOR_W-1:0];
            quot_next = {quot_reg[DIVIDEND_W-2:0], qbit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quot_reg <= quot_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quot_reg;

endmodule

FILE: hdl/apo_mult.sv
// ----------------------------------------------------------------------------
// apo_mult: shared unsigned multiplier with a registered product
// The product of the operands presented in one cycle is available the next.
// ----------------------------------------------------------------------------
module apo_mult #(
    parameter int A_W = 33,
    parameter int B_W = 38
) (
    input  logic               aclk,
    input  logic [A_W-1:0]     op_a,
    input  logic [B_W-1:0]     op_b,
    output logic [A_W+B_W-1:0] product
);

    logic [A_W+B_W-1:0] prod_reg;

    // Product register; no control state to reset.
    always_ff @(posedge aclk) begin
        prod_reg <= (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);
    end

    assign product = prod_reg;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the acceleration observer
// Streams directed and random samples, drive updates and clears through the
// block under several register settings, predicts estimates with an internal
// bit-exact filter model or a typed row; compares each result beat in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int DRAIN_CYCLES   = 500;
    localparam logic [62:0] STAMP_MAX = {63{1'b1}};

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        restarted;
        logic        held;
    } estimate_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] sx, sy, sz;
        logic [62:0] stamp;
        logic [31:0] dx, dy;
        bit          typed;
        estimate_t   want;
    } item_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic [223:0]  s_tdata = '0;
    logic [1:0]    s_tuser = apo_pkg::CMD_SAMPLE;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [95:0]   m_tdata;
    logic [1:0]    m_tuser;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_index = apo_pkg::REG_TAU_X;
    logic [31:0]   cfg_data = '0;

    // Predictor state and register copies.
    longint        est_acc[3];
    longint        drive_acc[2];
    logic [62:0]   last_stamp;
    bit            primed;
    longint unsigned tau_ns[2];
    longint unsigned gap_ns;

    estimate_t     estimate_q[$];
    item_t         directed[$];
    int            error_count = 0;
    int            idle_cycles = 0;
    bit            steady = 0;
    int            m_stall_left = 0;
    logic [62:0]   stamp_now;

    always #6 aclk = ~aclk;

    accel_prediction_observer_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mostly short pauses, now and then a long one.
    function automatic int pause_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // Blend weight exp(-dt/tau) in unsigned Q1.16.
    function automatic longint unsigned alpha_for(longint unsigned dt, longint unsigned tau);
        longint unsigned ratio, n, f, sum, term, a;
        ratio = ((dt & 64'hFFFF_FFFF) << 24) / tau;
        if (ratio >= (64'd32 << 24))
            return 64'd0;
        n = ratio >> 24;
        f = (ratio & 64'hFF_FFFF) << 8;
        sum = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int k = 1; k <= apo_pkg::TAYLOR_TERMS; k++) begin
            term = ((term * f) >> 32) / 64'(k);
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        for (longint unsigned i = 0; i < n; i++)
            sum = (sum * 64'(apo_pkg::E1_Q32) + 64'h8000_0000) >> 32;
        a = (sum + 64'd32768) >> 16;
        return (a > 64'd65536) ? 64'd65536 : a;
    endfunction

    // d * alpha / 2^16, rounded half away from zero.
    function automatic longint weigh(longint d, longint unsigned alpha);
        bit neg;
        longint unsigned mag, r;
        neg = d < 0;
        mag = neg ? -d : d;
        r = (((mag >> 24) * alpha) << 8) + (((mag & 64'hFF_FFFF) * alpha + 64'd32768) >> 16);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // Advance the filter model by one accepted beat; queue the estimate it yields.
    task automatic filter_step(input item_t it);
        longint meas[3];
        longint unsigned dt, alpha;
        longint pred;
        estimate_t res;
        case (it.cmd)
            apo_pkg::CMD_DRIVE: begin
                drive_acc[0] = longint'(signed'(it.dx));
                drive_acc[1] = longint'(signed'(it.dy));
            end
            apo_pkg::CMD_CLEAR: begin
                est_acc = '{0, 0, 0};
                drive_acc = '{0, 0};
                last_stamp = '0;
                primed = 0;
            end
            apo_pkg::CMD_SAMPLE: begin
                meas[0] = longint'(signed'(it.sx));
                meas[1] = longint'(signed'(it.sy));
                meas[2] = longint'(signed'(it.sz));
                res.restarted = 1'b0;
                res.held = 1'b0;
                if (primed && it.stamp == last_stamp) begin
                    res.held = 1'b1;
                end else if (!primed || it.stamp < last_stamp ||
                             64'(it.stamp - last_stamp) > gap_ns) begin
                    est_acc = meas;
                    last_stamp = it.stamp;
                    primed = 1;
                    res.restarted = 1'b1;
                end else begin
                    dt = 64'(it.stamp - last_stamp);
                    for (int ax = 0; ax < 2; ax++) begin
                        if (tau_ns[ax] == 0) begin
                            est_acc[ax] = meas[ax];
                        end else begin
                            alpha = alpha_for(dt, tau_ns[ax]);
                            pred = drive_acc[ax] + weigh(est_acc[ax] - drive_acc[ax], alpha);
                            est_acc[ax] = meas[ax] + weigh(pred - meas[ax], alpha);
                        end
                    end
                    est_acc[2] = meas[2];
                    last_stamp = it.stamp;
                end
                res.x = est_acc[0][31:0];
                res.y = est_acc[1][31:0];
                res.z = est_acc[2][31:0];
                estimate_q = {estimate_q, (it.typed ? it.want : res)};
            end
            default: ;
        endcase
    endtask

    // Offer one beat, wait for acceptance, then maybe leave a gap.
    task automatic send_item(input item_t it);
        s_tdata <= {1'b0, it.dy, it.dx, it.stamp, it.sz, it.sy, it.sx};
        s_tuser <= it.cmd;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        filter_step(it);
        if (!steady && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat (pause_len()) @(posedge aclk);
        end
    endtask

    // Register write, issued only with nothing outstanding.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            apo_pkg::REG_TAU_X: tau_ns[0] = 64'(val);
            apo_pkg::REG_TAU_Y: tau_ns[1] = 64'(val);
            apo_pkg::REG_GAP:   gap_ns = 64'(val);
            default: ;
        endcase
        // An idle wait keeps the next write's drive apart from this release.
        @(posedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (estimate_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic add_row(input logic [1:0] cmd, input logic [31:0] sx, sy, sz,
                           input logic [62:0] stamp, input logic [31:0] dx, dy,
                           input bit typed, input estimate_t want);
        item_t it;
        it.cmd = cmd; it.sx = sx; it.sy = sy; it.sz = sz; it.stamp = stamp;
        it.dx = dx; it.dy = dy; it.typed = typed; it.want = want;
        directed = {directed, it};
    endtask

    // Random beat: mostly samples a short step ahead, with drives, clears and noise.
    task automatic random_item();
        item_t it;
        int pick;
        it.typed = 0;
        it.want = '0;
        it.sx = $urandom; it.sy = $urandom; it.sz = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            it.sx = $signed($urandom_range(0, 4000)) - 2000;
            it.sy = $signed($urandom_range(0, 4000)) - 2000;
        end
        it.dx = $urandom; it.dy = $urandom;
        it.cmd = apo_pkg::CMD_SAMPLE;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            it.cmd = apo_pkg::CMD_DRIVE;
        end else if (pick < 12) begin
            it.cmd = apo_pkg::CMD_CLEAR;
        end else if (pick < 14) begin
            it.cmd = CMD_UNUSED;
        end else if (pick < 19) begin
            // duplicate stamp
        end else if (pick < 23) begin
            stamp_now = stamp_now - $urandom_range(1, 1000);
        end else if (pick < 27) begin
            stamp_now = stamp_now + 63'(gap_ns) + $urandom_range(1, 1000);
        end else if (pick < 29) begin
            stamp_now = 63'({$urandom, $urandom});
        end else if (pick < 35) begin
            stamp_now = stamp_now + $urandom;
        end else begin
            stamp_now = stamp_now + $urandom_range(1, 3000000);
        end
        it.stamp = stamp_now;
        send_item(it);
    endtask

    // Stimulus and register phases.
    initial begin
        estimate_t none;
        none = '0;
        est_acc = '{0, 0, 0};
        drive_acc = '{0, 0};
        last_stamp = '0;
        primed = 0;
        tau_ns = '{0, 0};
        gap_ns = 64'(apo_pkg::GAP_RESET);
        stamp_now = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows under the reset register values.
        add_row(apo_pkg::CMD_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 63'd0, 0, 0, 1,
                '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1, 1'b0});
        add_row(apo_pkg::CMD_SAMPLE, 32'h1, 32'h2, 32'h3, 63'd0, 0, 0, 1,
                '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0, 1'b1});
        add_row(apo_pkg::CMD_SAMPLE, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 63'd100, 0, 0, 1,
                '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0});
        add_row(apo_pkg::CMD_DRIVE, 0, 0, 0, 63'd0, 32'h7FFF_FFFF, 32'h8000_0000, 0, none);
        add_row(apo_pkg::CMD_SAMPLE, 32'd5, 32'd6, 32'd7, 63'd50, 0, 0, 1,
                '{32'd5, 32'd6, 32'd7, 1'b1, 1'b0});
        add_row(apo_pkg::CMD_SAMPLE, 32'd9, 32'd9, 32'h8000_0000, 63'd250000050, 0, 0, 1,
                '{32'd9, 32'd9, 32'h8000_0000, 1'b0, 1'b0});
        add_row(apo_pkg::CMD_SAMPLE, 32'd4, 32'd3, 32'd2, 63'd500000051, 0, 0, 1,
                '{32'd4, 32'd3, 32'd2, 1'b1, 1'b0});
        add_row(CMD_UNUSED, '1, '1, '1, STAMP_MAX, '1, '1, 0, none);
        add_row(apo_pkg::CMD_CLEAR, 0, 0, 0, 63'd0, 0, 0, 0, none);
        add_row(apo_pkg::CMD_SAMPLE, 32'd11, 32'd12, 32'd13, 63'd1, 0, 0, 1,
                '{32'd11, 32'd12, 32'd13, 1'b1, 1'b0});
        add_row(apo_pkg::CMD_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, STAMP_MAX,
                0, 0, 1, '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0});
        add_row(apo_pkg::CMD_DRIVE, 0, 0, 0, 63'd0, 32'h8000_0000, 32'h7FFF_FFFF, 0, none);
        add_row(apo_pkg::CMD_SAMPLE, 32'd1, 32'd1, 32'd1, 63'd0, 0, 0, 1,
                '{32'd1, 32'd1, 32'd1, 1'b1, 1'b0});
        add_row(apo_pkg::CMD_SAMPLE, 32'd2, 32'd2, 32'd2, 63'd1000, 0, 0, 0, none);
        foreach (directed[i])
            send_item(directed[i]);
        settle();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(apo_pkg::REG_TAU_X, 32'd1000000);
                    write_reg(apo_pkg::REG_TAU_Y, 32'd3000000);
                    write_reg(apo_pkg::REG_GAP, apo_pkg::GAP_RESET);
                end
                1: begin
                    write_reg(apo_pkg::REG_TAU_X, 32'd1);
                    write_reg(apo_pkg::REG_TAU_Y, 32'hFFFF_FFFF);
                    write_reg(apo_pkg::REG_GAP, 32'hFFFF_FFFF);
                end
                2: begin
                    write_reg(apo_pkg::REG_TAU_X, 32'hFFFF_FFFF);
                    write_reg(apo_pkg::REG_TAU_Y, 32'd0);
                    write_reg(apo_pkg::REG_GAP, 32'd0);
                end
                default: begin
                    write_reg(apo_pkg::REG_TAU_X, 32'd20000000);
                    write_reg(apo_pkg::REG_TAU_Y, 32'd700000);
                    write_reg(apo_pkg::REG_GAP, 32'd5000000);
                end
            endcase
            steady = (ph == 3);
            for (int n = 0; n < 150; n++)
                random_item();
            steady = 0;
            settle();
        end

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side: random stalls, in-order compare, watchdog.
    always @(posedge aclk) begin
        estimate_t got, want;
        if (m_stall_left > 0) begin
            m_stall_left <= m_stall_left - 1;
            m_tready <= 1'b0;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            m_stall_left <= pause_len();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end

        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end

        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0], m_tuser[1]};
            if (estimate_q.size() == 0) begin
                $display("%0t: unexpected result beat, actual %h", $time, got);
                error_count <= error_count + 1;
            end else begin
                want = estimate_q.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                    got.restarted !== want.restarted || got.held !== want.held) begin
                    $display("%0t: mismatch x/y/z/restarted/held expected %h %h %h %b %b",
                             $time, want.x, want.y, want.z, want.restarted, want.held);
                    $display("%0t: actual %h %h %h %b %b",
                             $time, got.x, got.y, got.z, got.restarted, got.held);
                    error_count <= error_count + 1;
                end
            end
        end
    end

endmodule

FILE: files.f
hdl/apo_pkg.sv
hdl/apo_divider.sv
hdl/apo_mult.sv
hdl/accel_prediction_observer_unit.sv
tb/testbench.sv
